// File: design/gaussian_window_spectrogram_macros.svh
// assertion macros used by the spectrogram top level
`ifndef GAUSSIAN_WINDOW_SPECTROGRAM_MACROS_SVH
`define GAUSSIAN_WINDOW_SPECTROGRAM_MACROS_SVH

// same-cycle implication, disabled during reset
`define GWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gws assertion failed");

// next-cycle implication, disabled during reset
`define GWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gws assertion failed");

`endif

// File: design/gws_pkg.sv
// package: widths, fixed-point constants, flow type and q15 helper for the spectrogram
`timescale 1ns / 1ps
`default_nettype none

package gws_pkg;

  localparam int unsigned WindowSizeDef  = 64;
  localparam int unsigned NumFreqsDef    = 32;
  localparam int unsigned SigmaTenthsDef = 100;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 17;
  localparam int unsigned WeightW = SampleW + CoefW;
  localparam int unsigned MagW    = 30;
  localparam int unsigned FreqW   = 5;
  localparam int unsigned FrameW  = 24;
  localparam int unsigned CountW  = 25;

  localparam longint Q30       = 64'sd1073741824;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint InvEQ30   = 64'sd395007542;

  // taylor divisors: exp terms, cos terms (2i-1)(2i), sin terms (2i)(2i+1)
  localparam longint ExpDiv [14] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14};
  localparam longint CosDiv [12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};
  localparam longint SinDiv [12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  // weighted sample with its framing marks, handed cell to cell
  typedef struct packed {
    logic                      vld;
    logic                      start;
    logic                      stop;
    logic signed [WeightW-1:0] w;
  } gws_flow_t;

  // q2.30 to q1.15, round half up, clamp to 0..1.0
  function automatic logic [CoefW-1:0] q30_to_q15(input longint v);
    longint r;
    r = (v < 0) ? 64'sd0 : v;
    r = (r + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    return CoefW'(r);
  endfunction

endpackage

`default_nettype wire

// File: design/gaussian_window_spectrogram.sv
// top level: sample window, gaussian feeder, bin cell chain and result unload
// a sample that completes no frame only shifts into the window; a frame sample
// runs the feeder sweep, the chain skew and the root, then unloads
// NumFreqs output words; no new sample is taken until the last word leaves
// rst_ni clears count, fsm and chain control; the window stays unknown until filled
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_window_spectrogram_macros.svh"

module gaussian_window_spectrogram
  import gws_pkg::*;
#(
  parameter int unsigned WindowSize  = WindowSizeDef,
  parameter int unsigned NumFreqs    = NumFreqsDef,
  parameter int unsigned SigmaTenths = SigmaTenthsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [MagW-1:0]           magnitude_o,
  output logic [FreqW-1:0]          freq_index_o,
  output logic [FrameW-1:0]         frame_index_o,
  output logic                      last_of_frame_o,
  output logic                      last_of_vector_o
);

  localparam int unsigned IdxW  = $clog2(WindowSize);
  localparam int unsigned HeldW = $clog2(WindowSize + 1);
  localparam int unsigned BinW  = (NumFreqs > 1) ? $clog2(NumFreqs) : 1;
  localparam longint      SigSq = longint'(SigmaTenths) * longint'(SigmaTenths);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  // gaussian weights in q1.15, centered at WindowSize/2
  function automatic logic [WindowSize*CoefW-1:0] build_gauss();
    logic [WindowSize*CoefW-1:0] tab;
    longint                      d, xq, m, fr, term, sum;
    tab = '0;
    for (int n = 0; n < WindowSize; n++) begin
      d    = longint'(n) - longint'(WindowSize / 2);
      xq   = ((64'sd50 * d * d) <<< 30) / SigSq;
      m    = xq >>> 30;
      fr   = xq & (Q30 - 64'sd1);
      term = Q30;
      sum  = Q30;
      for (int i = 0; i < 14; i++) begin
        term = -((term * fr / Q30) / ExpDiv[i]);
        sum += term;
      end
      if (m > 64'sd20) sum = 64'sd0;
      // integer part of the exponent: repeated multiply by 1/e
      for (int j = 0; j < 20; j++) begin
        if (longint'(j) < m && sum > 64'sd0) sum = (sum * InvEQ30 + Q30 / 2) >>> 30;
      end
      tab[n*CoefW +: CoefW] = q30_to_q15(sum);
    end
    return tab;
  endfunction

  localparam logic [WindowSize*CoefW-1:0] GaussFlat = build_gauss();

  logic [1:0]                state_q;
  logic [CountW-1:0]         count_q, cnt_inc, frm_raw;
  logic                      full;
  logic [HeldW-1:0]          held, off_q, diff;
  logic [IdxW-1:0]           cyc_q, n_idx;
  logic                      in_win;
  logic [FrameW-1:0]         frame_q, frame_d;
  logic                      lastv_q;
  logic [BinW-1:0]           bin_q;
  logic                      in_acc, out_acc, go_frame, run, shift;
  logic signed [SampleW-1:0] win_q [WindowSize];
  logic signed [CoefW-1:0]   gcoef;
  logic signed [WeightW-1:0] w_q;
  logic                      fvld_q, fstart_q, fstop_q;

  gws_flow_t                 flow [NumFreqs+1];
  logic [MagW-1:0]           res  [NumFreqs+1];
  logic [NumFreqs-1:0]       done;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_acc    = out_valid_o & out_ready_i;
  assign run        = (state_q == StRun);
  assign shift      = out_acc;

  // saturating count of samples seen in this vector, including this one
  assign cnt_inc  = (&count_q) ? count_q : count_q + 1'b1;
  assign full     = (cnt_inc >= CountW'(WindowSize));
  assign go_frame = full | last_i;
  assign held     = full ? HeldW'(WindowSize) : HeldW'(cnt_inc);
  assign frm_raw  = cnt_inc - CountW'(WindowSize);
  assign frame_d  = !full ? '0 : (frm_raw[CountW-1] ? '1 : frm_raw[FrameW-1:0]);

  // samples always enter at the top; a short window sits above offset off_q
  assign diff   = HeldW'(cyc_q) - off_q;
  assign n_idx  = diff[IdxW-1:0];
  assign in_win = (HeldW'(cyc_q) >= off_q);
  assign gcoef  = GaussFlat[int'(n_idx)*CoefW +: CoefW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      cyc_q    <= '0;
      bin_q    <= '0;
      fvld_q   <= 1'b0;
      fstart_q <= 1'b0;
      fstop_q  <= 1'b0;
    end else begin
      fvld_q   <= run & in_win;
      fstart_q <= run & (cyc_q == '0);
      fstop_q  <= run & (cyc_q == IdxW'(WindowSize - 1));
      if (in_acc) count_q <= last_i ? '0 : cnt_inc;
      unique case (state_q)
        StIdle: begin
          if (in_acc && go_frame) begin
            state_q <= StRun;
            cyc_q   <= '0;
          end
        end
        StRun: begin
          cyc_q <= cyc_q + 1'b1;
          if (cyc_q == IdxW'(WindowSize - 1)) state_q <= StWait;
        end
        StWait: begin
          // the far cell finishes last
          if (done[NumFreqs-1]) begin
            state_q <= StOut;
            bin_q   <= '0;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            bin_q <= bin_q + 1'b1;
            if (bin_q == BinW'(NumFreqs - 1)) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // window: shift in on accept, rotate once around during the sweep
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < WindowSize - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WindowSize-1] <= sample_i;
      off_q   <= HeldW'(WindowSize) - held;
      frame_q <= frame_d;
      lastv_q <= last_i;
    end else if (run) begin
      for (int i = 0; i < WindowSize - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WindowSize-1] <= win_q[0];
    end
    w_q <= win_q[0] * gcoef;
  end

  assign flow[0]        = '{vld: fvld_q, start: fstart_q, stop: fstop_q, w: w_q};
  assign res[NumFreqs]  = '0;

  for (genvar f = 0; f < NumFreqs; f++) begin : g_cell
    gws_cell #(
      .WindowSize (WindowSize),
      .NumFreqs   (NumFreqs),
      .Freq       (f)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flow_i  (flow[f]),
      .flow_o  (flow[f+1]),
      .res_i   (res[f+1]),
      .shift_i (shift),
      .res_o   (res[f]),
      .done_o  (done[f])
    );
  end

  // results leave from the near cell and the chain moves up one per word
  assign out_valid_o      = (state_q == StOut);
  assign magnitude_o      = res[0];
  assign freq_index_o     = FreqW'(bin_q);
  assign frame_index_o    = frame_q;
  assign last_of_frame_o  = (bin_q == BinW'(NumFreqs - 1));
  assign last_of_vector_o = lastv_q & last_of_frame_o;

  // each cell starts in the cycle after its neighbour, so their finish pulses never coincide
  `GWS_ASSERT_SAME(a_done_onehot, clk_i, rst_ni, 1'b1, $onehot0(done))
  // the far cell only finishes while the fsm waits for it
  `GWS_ASSERT_SAME(a_done_in_wait, clk_i, rst_ni, done[NumFreqs-1], state_q == StWait)
  // a vector end clears the sample count
  `GWS_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_acc && last_i, count_q == '0)
  // the final bin of a frame returns the block to input
  `GWS_ASSERT_NEXT(a_frame_end_idle, clk_i, rst_ni, out_acc && last_of_frame_o,
                   in_ready_o && !out_valid_o)

endmodule

`default_nettype wire

// File: design/gws_cell.sv
// one frequency bin cell: complex mac, rounding, squared sum and bit-serial root
`timescale 1ns / 1ps
`default_nettype none

module gws_cell
  import gws_pkg::*;
#(
  parameter int unsigned WindowSize = WindowSizeDef,
  parameter int unsigned NumFreqs   = NumFreqsDef,
  parameter int unsigned Freq       = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gws_flow_t        flow_i,
  output gws_flow_t        flow_o,
  input  logic [MagW-1:0]  res_i,
  input  logic             shift_i,
  output logic [MagW-1:0]  res_o,
  output logic             done_o
);

  localparam int unsigned PhW   = (NumFreqs > 1) ? $clog2(NumFreqs) : 1;
  localparam int unsigned ProdW = WeightW + CoefW;
  localparam int unsigned AccW  = 47 + $clog2(WindowSize);
  localparam int unsigned TW    = AccW - 22;
  localparam int unsigned RtW   = (TW + 1 > 31) ? TW + 1 : 31;
  localparam int unsigned SqW   = 2 * RtW;
  localparam int unsigned RemW  = RtW + 2;
  localparam int unsigned ItW   = $clog2(RtW);

  localparam logic [2:0] FinIdle   = 3'd0;
  localparam logic [2:0] FinRound  = 3'd1;
  localparam logic [2:0] FinSquare = 3'd2;
  localparam logic [2:0] FinSum    = 3'd3;
  localparam logic [2:0] FinRoot   = 3'd4;

  function automatic logic [2*NumFreqs*CoefW-1:0] build_trig();
    logic [2*NumFreqs*CoefW-1:0] tab;
    int                          q;
    int                          r;
    longint                      phi, x2, ct, cs, st, ss;
    logic signed [CoefW-1:0]     c0, s0, cv, sv;
    tab = '0;
    for (int k = 0; k < NumFreqs; k++) begin
      q   = (4 * k) / NumFreqs;
      r   = 4 * k - q * NumFreqs;
      phi = HalfPiQ30 * longint'(r) / NumFreqs;
      x2  = (phi * phi) >>> 30;
      ct  = Q30;
      cs  = Q30;
      st  = phi;
      ss  = phi;
      for (int i = 0; i < 12; i++) begin
        ct = -((ct * x2 / Q30) / CosDiv[i]);
        cs += ct;
        st = -((st * x2 / Q30) / SinDiv[i]);
        ss += st;
      end
      c0 = q30_to_q15(cs);
      s0 = q30_to_q15(ss);
      case (q[1:0])
        2'd0:    begin cv = c0;  sv = s0;  end
        2'd1:    begin cv = -s0; sv = c0;  end
        2'd2:    begin cv = -c0; sv = -s0; end
        default: begin cv = s0;  sv = -c0; end
      endcase
      tab[k*CoefW +: CoefW]              = cv;
      tab[(NumFreqs+k)*CoefW +: CoefW]   = sv;
    end
    return tab;
  endfunction

  localparam logic [2*NumFreqs*CoefW-1:0] TrigFlat = build_trig();
  localparam logic [AccW-1:0]             RndHalf  = AccW'(1) << 21;

  logic [PhW-1:0]            ph_q, ph_use, ph_nxt;
  logic [PhW:0]              ph_sum;
  logic signed [CoefW-1:0]   cos_c, sin_c;
  logic signed [ProdW-1:0]   p_re_q, p_im_q;
  logic                      pvld_q, pstart_q, pstop_q;
  logic signed [AccW-1:0]    acc_re_q, acc_im_q, ext_re, ext_im;
  logic [AccW-1:0]           abs_re, abs_im, rnd_re, rnd_im;
  logic [TW-1:0]             t_re_q, t_im_q;
  logic [2*TW-1:0]           sq_re_q, sq_im_q;
  logic [SqW-1:0]            v_q;
  logic [RemW-1:0]           rem_q, rem2, trial;
  logic [RtW-1:0]            root_q, root_nxt;
  logic                      take;
  logic [MagW-1:0]           mag, res_q;
  logic [2:0]                fin_q;
  logic [ItW-1:0]            it_q;
  logic                      root_end;

  // phase of (freq * n) mod bins, advanced once per valid sample
  assign ph_use = flow_i.start ? '0 : ph_q;
  assign ph_sum = {1'b0, ph_use} + (PhW+1)'(Freq);
  assign ph_nxt = (ph_sum >= (PhW+1)'(NumFreqs)) ?
                  PhW'(ph_sum - (PhW+1)'(NumFreqs)) : ph_sum[PhW-1:0];

  assign cos_c = TrigFlat[int'(ph_use)*CoefW +: CoefW];
  assign sin_c = TrigFlat[(NumFreqs + int'(ph_use))*CoefW +: CoefW];

  assign ext_re = AccW'(p_re_q);
  assign ext_im = AccW'(p_im_q);

  // only the magnitude of the rounded value feeds the squares
  assign abs_re = acc_re_q[AccW-1] ? AccW'(-acc_re_q) : AccW'(acc_re_q);
  assign abs_im = acc_im_q[AccW-1] ? AccW'(-acc_im_q) : AccW'(acc_im_q);
  assign rnd_re = abs_re + RndHalf;
  assign rnd_im = abs_im + RndHalf;

  assign rem2     = {rem_q[RemW-3:0], v_q[SqW-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign take     = (rem2 >= trial);
  assign root_nxt = {root_q[RtW-2:0], take};
  assign mag      = (|root_nxt[RtW-1:MagW]) ? '1 : root_nxt[MagW-1:0];
  assign root_end = (fin_q == FinRoot) && (it_q == ItW'(RtW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_o   <= '0;
      ph_q     <= '0;
      pvld_q   <= 1'b0;
      pstart_q <= 1'b0;
      pstop_q  <= 1'b0;
      fin_q    <= FinIdle;
      it_q     <= '0;
      done_o   <= 1'b0;
    end else begin
      flow_o   <= flow_i;
      ph_q     <= flow_i.vld ? ph_nxt : ph_use;
      pvld_q   <= flow_i.vld;
      pstart_q <= flow_i.start;
      pstop_q  <= flow_i.stop;
      done_o   <= root_end;
      unique case (fin_q)
        FinIdle: begin
          if (pstop_q) fin_q <= FinRound;
        end
        FinRound:  fin_q <= FinSquare;
        FinSquare: fin_q <= FinSum;
        FinSum: begin
          fin_q <= FinRoot;
          it_q  <= '0;
        end
        FinRoot: begin
          it_q <= it_q + 1'b1;
          if (root_end) fin_q <= FinIdle;
        end
        default: fin_q <= FinIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_re_q <= flow_i.w * cos_c;
    p_im_q <= flow_i.w * sin_c;
    if (pstart_q) begin
      acc_re_q <= pvld_q ? ext_re : '0;
      acc_im_q <= pvld_q ? ext_im : '0;
    end else if (pvld_q) begin
      acc_re_q <= acc_re_q + ext_re;
      acc_im_q <= acc_im_q + ext_im;
    end
    if (fin_q == FinRound) begin
      t_re_q <= rnd_re[AccW-1:22];
      t_im_q <= rnd_im[AccW-1:22];
    end
    if (fin_q == FinSquare) begin
      sq_re_q <= t_re_q * t_re_q;
      sq_im_q <= t_im_q * t_im_q;
    end
    if (fin_q == FinSum) begin
      v_q    <= SqW'(sq_re_q) + SqW'(sq_im_q);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (fin_q == FinRoot) begin
      rem_q  <= take ? (rem2 - trial) : rem2;
      root_q <= root_nxt;
      v_q    <= v_q << 2;
    end
    if (shift_i) begin
      res_q <= res_i;
    end else if (root_end) begin
      res_q <= mag;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// testbench for the gaussian window spectrogram: directed and random sample vectors against a bit-true predictor
`timescale 1ns / 1ps

module testbench;
  import gws_pkg::*;

  localparam int unsigned Win = WindowSizeDef;
  localparam int unsigned Nf = NumFreqsDef;
  localparam int unsigned Sigma = SigmaTenthsDef;
  localparam int unsigned CountMax = 33554431;
  localparam int unsigned FrameMax = 16777215;
  localparam longint unsigned MagMax = 64'd1073741823;
  localparam int unsigned StallLimit = 5000;

  // one expected output word
  typedef struct {
    logic [MagW-1:0]   mag;
    logic [FreqW-1:0]  freq;
    logic [FrameW-1:0] frame;
    logic              lof;
    logic              lov;
  } spec_word_t;

  // spectrogram predictor plus the queue of words still owed by the block
  class spectrum_board;
    longint gauss_q15 [Win];
    longint cos_q15 [Nf];
    longint sin_q15 [Nf];
    logic signed [SampleW-1:0] window_buf [Win];
    int unsigned held_count;
    spec_word_t owed [$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned frames_seen;

    function new();
      build_coefs();
      held_count = 0;
      mismatches = 0;
      words_seen = 0;
      frames_seen = 0;
    endfunction

    // q2.30 to q1.15, half up, clamped to 0..1.0
    function longint to_q15(longint v);
      longint r;
      r = (v < 0) ? 0 : v;
      r = (r + 16384) >>> 15;
      if (r > 32768) r = 32768;
      return r;
    endfunction

    function void build_coefs();
      longint d, xq, m, fr, term, acc, sig, phi, x2, ct, cs, st, ss, c0, s0;
      int q, r;
      sig = Sigma;
      for (int n = 0; n < Win; n++) begin
        d = longint'(n) - longint'(Win / 2);
        xq = ((50 * d * d) <<< 30) / (sig * sig);
        m = xq >>> 30;
        fr = xq & (Q30 - 1);
        term = Q30;
        acc = Q30;
        for (int i = 1; i <= 14; i++) begin
          term = -((term * fr) / Q30) / longint'(i);
          acc += term;
        end
        if (m > 20) acc = 0;
        // whole part of the exponent: repeated multiply by 1/e
        while (m > 0 && acc > 0) begin
          acc = (acc * InvEQ30 + (Q30 / 2)) >>> 30;
          m--;
        end
        gauss_q15[n] = to_q15(acc);
      end
      for (int k = 0; k < Nf; k++) begin
        q = (4 * k) / Nf;
        r = 4 * k - q * Nf;
        phi = (HalfPiQ30 * longint'(r)) / longint'(Nf);
        x2 = (phi * phi) >>> 30;
        ct = Q30; cs = Q30; st = phi; ss = phi;
        for (int i = 1; i <= 12; i++) begin
          ct = -((ct * x2) / Q30) / longint'((2 * i - 1) * (2 * i));
          cs += ct;
          st = -((st * x2) / Q30) / longint'((2 * i) * (2 * i + 1));
          ss += st;
        end
        c0 = to_q15(cs);
        s0 = to_q15(ss);
        // quadrant folding
        case (q & 3)
          0: begin cos_q15[k] = c0;  sin_q15[k] = s0;  end
          1: begin cos_q15[k] = -s0; sin_q15[k] = c0;  end
          2: begin cos_q15[k] = -c0; sin_q15[k] = -s0; end
          default: begin cos_q15[k] = s0; sin_q15[k] = -c0; end
        endcase
      end
    endfunction

    // round q.30 sums to q.8, half away from zero
    function longint round_q8(longint v);
      if (v >= 0) return (v + (64'sd1 <<< 21)) >>> 22;
      return -((-v + (64'sd1 <<< 21)) >>> 22);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // accepted sample: update the window and queue any frame it completes
    function void note_sample(logic signed [SampleW-1:0] s, logic is_last);
      int unsigned held, frame;
      longint re, im, wt, r8, i8;
      longint unsigned mag;
      spec_word_t wd;
      if (held_count < Win) begin
        window_buf[held_count] = s;
      end else begin
        for (int n = 0; n + 1 < Win; n++) window_buf[n] = window_buf[n + 1];
        window_buf[Win - 1] = s;
      end
      if (held_count < CountMax) held_count++;
      if (held_count >= Win || is_last) begin
        held = (held_count < Win) ? held_count : Win;
        frame = (held_count >= Win) ? held_count - Win : 0;
        if (frame > FrameMax) frame = FrameMax;
        frames_seen++;
        for (int f = 0; f < Nf; f++) begin
          re = 0;
          im = 0;
          for (int n = 0; n < held; n++) begin
            wt = longint'(window_buf[n]) * gauss_q15[n];
            re += wt * cos_q15[(f * n) % Nf];
            im += wt * sin_q15[(f * n) % Nf];
          end
          r8 = round_q8(re);
          i8 = round_q8(im);
          mag = int_sqrt(longint'(r8 * r8) + longint'(i8 * i8));
          if (mag > MagMax) mag = MagMax;
          wd.mag = mag[MagW-1:0];
          wd.freq = f[FreqW-1:0];
          wd.frame = frame[FrameW-1:0];
          wd.lof = (f == Nf - 1);
          wd.lov = is_last && (f == Nf - 1);
          owed.push_back(wd);
        end
      end
      if (is_last) held_count = 0;
    endfunction

    function void check_word(spec_word_t got);
      spec_word_t want;
      words_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: mag %0d bin %0d frame %0d", got.mag, got.freq, got.frame);
        return;
      end
      want = owed.pop_front();
      if (got.mag !== want.mag || got.freq !== want.freq || got.frame !== want.frame ||
          got.lof !== want.lof || got.lov !== want.lov) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp mag %0d bin %0d frame %0d lof %0b lov %0b, ",
                    "got mag %0d bin %0d frame %0d lof %0b lov %0b"},
                   want.mag, want.freq, want.frame, want.lof, want.lov,
                   got.mag, got.freq, got.frame, got.lof, got.lov);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic last_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [MagW-1:0] magnitude_o;
  logic [FreqW-1:0] freq_index_o;
  logic [FrameW-1:0] frame_index_o;
  logic last_of_frame_o;
  logic last_of_vector_o;

  spectrum_board board;
  bit calm_phase;        // no idling on either side while set
  int unsigned samples_sent;
  int unsigned vectors_sent;
  int unsigned quiet_cycles;
  bit in_fire, out_fire;

  gaussian_window_spectrogram DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .magnitude_o     (magnitude_o),
    .freq_index_o    (freq_index_o),
    .frame_index_o   (frame_index_o),
    .last_of_frame_o (last_of_frame_o),
    .last_of_vector_o(last_of_vector_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle with a chance of about 14 in 100, none during the calm stretch
  function automatic bit idle_roll();
    return !calm_phase && ($urandom_range(99) < 14);
  endfunction

  // present one sample word and hold it until the block takes it
  task automatic push_sample(logic signed [SampleW-1:0] s, logic is_last);
    if (idle_roll()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (idle_roll());
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_i <= is_last;
    // ready is stable at the falling edge, so the next rising edge takes the word
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    board.note_sample(s, is_last);
    samples_sent++;
    if (is_last) vectors_sent++;
  endtask

  // random sample, biased toward the extremes now and then
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic push_vector(int unsigned len);
    for (int i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
  endtask

  // receiver: ready changes on rising edges, words are taken at the falling edge before
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !idle_roll();
  end

  always @(negedge clk_i) begin
    spec_word_t got;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (out_fire) begin
      got.mag = magnitude_o;
      got.freq = freq_index_o;
      got.frame = frame_index_o;
      got.lof = last_of_frame_o;
      got.lov = last_of_vector_o;
      board.check_word(got);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned wait_cycles;
    board = new();
    calm_phase = 1'b0;
    samples_sent = 0;
    vectors_sent = 0;
    in_valid_i = 1'b0;
    sample_i = '0;
    last_i = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-sample vectors at the extremes (short-vector zero padding)
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh0000, 1'b1);
    // short vector of mixed extremes
    push_sample(16'shffff, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0001, 1'b1);
    // two more short vectors, checking the count restarts after last
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b1);

    // random vectors: short ones, exact full windows and longer ones with sliding frames
    while (samples_sent < 330) begin
      calm_phase = (samples_sent >= 150 && samples_sent < 230);
      case ($urandom_range(5))
        0, 1: push_vector($urandom_range(1, Win - 1));
        2: push_vector(Win);
        default: push_vector(Win + $urandom_range(1, 6));
      endcase
    end
    calm_phase = 1'b0;
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (board.owed.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);

    $display("covered %0d samples in %0d vectors, %0d frames, %0d words checked",
             samples_sent, vectors_sent, board.frames_seen, board.words_seen);
    $display("mismatches %0d, words still owed %0d", board.mismatches, board.owed.size());
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/gws_pkg.sv
design/gws_cell.sv
design/gaussian_window_spectrogram.sv
verif/testbench.sv
